// ----- rtl/hbd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package hbd_pkg;

	localparam logic [7:0] FLAG_PATTERN    = 8'h7E;
	localparam logic [15:0] CRC_POLY       = 16'h8408;
	localparam logic [15:0] CRC_INIT       = 16'hFFFF;
	localparam logic [7:0] MAX_FRAME_BYTES = 8'd255;
	localparam logic [7:0] MIN_LEN_RESET   = 8'd17;
	localparam logic [2:0] STUFF_RUN       = 3'd5;
	localparam logic [2:0] ONES_SAT        = 3'd7;
	localparam logic [2:0] LAST_BIT_POS    = 3'd7;

	// word kinds passed from front to back
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_BYTE = 2'd1;
	localparam logic [1:0] EV_FLAG = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
	} ev_t;

	// reflected CRC-16/X-25, one byte
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/hbd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hbd_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic         line_bit,
	input  wire logic         q_full,
	output logic              q_push,
	output hbd_pkg::ev_t      q_ev
);

	logic [7:0] raw_q;
	logic [2:0] ones_q;
	logic [7:0] asm_q;
	logic [2:0] bits_q;

	logic       accept;
	logic [7:0] raw_n;
	logic       is_flag;
	logic       take;
	logic       complete;
	logic [7:0] asm_n;
	logic [2:0] ones_n;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign raw_n    = {raw_q[6:0], line_bit};
	assign is_flag  = (raw_n == hbd_pkg::FLAG_PATTERN);

	always_comb begin
		if (line_bit) begin
			take   = 1'b1;
			ones_n = (ones_q < hbd_pkg::ONES_SAT) ? ones_q + 3'd1 : ones_q;
		end else begin
			// stuffed zero after five ones is dropped
			take   = (ones_q < hbd_pkg::STUFF_RUN);
			ones_n = 3'd0;
		end
	end

	assign asm_n    = take ? {line_bit, asm_q[7:1]} : asm_q;
	assign complete = take && (bits_q == hbd_pkg::LAST_BIT_POS);

	assign q_push = accept;
	always_comb begin
		q_ev.data = asm_n;
		if (is_flag) begin
			q_ev.kind = hbd_pkg::EV_FLAG;
		end else if (complete) begin
			q_ev.kind = hbd_pkg::EV_BYTE;
		end else begin
			q_ev.kind = hbd_pkg::EV_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q  <= '0;
			ones_q <= '0;
			asm_q  <= '0;
			bits_q <= '0;
		end else if (accept) begin
			if (is_flag) begin
				raw_q  <= '0;
				ones_q <= '0;
				asm_q  <= '0;
				bits_q <= '0;
			end else begin
				raw_q  <= raw_n;
				ones_q <= ones_n;
				asm_q  <= asm_n;
				bits_q <= complete ? 3'd0 : bits_q + {2'b00, take};
			end
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hbd_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hbd_queue (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire hbd_pkg::ev_t push_ev,
	output logic              full,
	input  wire logic         pop,
	output logic              empty,
	output hbd_pkg::ev_t      pop_ev
);

	hbd_pkg::ev_t mem_q [2];
	logic         wr_q;
	logic         rd_q;
	logic [1:0]   cnt_q;
	logic         do_push;
	logic         do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_ev  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_ev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hbd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hbd_back (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	input  wire logic [7:0]   cfg_data,
	input  wire logic         q_empty,
	input  wire hbd_pkg::ev_t q_ev,
	output logic              q_pop,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              byte_valid,
	output logic [7:0]        data_byte,
	output logic [7:0]        byte_index,
	output logic              frame_end,
	output logic              frame_good,
	output logic [7:0]        frame_length
);

	logic [7:0]  min_len_q;
	logic [7:0]  count_q;
	logic [15:0] crc_q;
	logic [7:0]  held0_q;
	logic [7:0]  held1_q;
	logic        out_valid_q;

	logic        go;
	logic        wrap;
	logic [7:0]  count_b;
	logic [15:0] crc_b;
	logic        fcs_ok;

	assign q_pop = !q_empty && (!out_valid_q || !out_stall);
	assign go    = q_pop;
	assign out_valid = out_valid_q;

	assign wrap    = (count_q >= hbd_pkg::MAX_FRAME_BYTES);
	assign count_b = wrap ? 8'd0 : count_q;
	assign crc_b   = wrap ? hbd_pkg::CRC_INIT : crc_q;
	assign fcs_ok  = (count_q >= min_len_q) && (count_q >= 8'd2)
		&& ((crc_q ^ hbd_pkg::CRC_INIT) == {held1_q, held0_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_len_q <= hbd_pkg::MIN_LEN_RESET;
		end else if (cfg_valid) begin
			min_len_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			crc_q       <= hbd_pkg::CRC_INIT;
			held0_q     <= '0;
			held1_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (go) begin
				unique case (q_ev.kind)
					hbd_pkg::EV_FLAG: begin
						count_q <= '0;
						crc_q   <= hbd_pkg::CRC_INIT;
						held0_q <= '0;
						held1_q <= '0;
					end
					hbd_pkg::EV_BYTE: begin
						// CRC trails by two bytes so the FCS never enters it
						crc_q   <= (count_b >= 8'd2) ? hbd_pkg::crc_byte(crc_b, held0_q) : crc_b;
						held0_q <= held1_q;
						held1_q <= q_ev.data;
						count_q <= count_b + 8'd1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			byte_valid   <= (q_ev.kind == hbd_pkg::EV_BYTE);
			data_byte    <= (q_ev.kind == hbd_pkg::EV_BYTE) ? q_ev.data : 8'd0;
			byte_index   <= (q_ev.kind == hbd_pkg::EV_BYTE) ? count_b : 8'd0;
			frame_end    <= (q_ev.kind == hbd_pkg::EV_FLAG);
			frame_good   <= (q_ev.kind == hbd_pkg::EV_FLAG) && fcs_ok;
			frame_length <= (q_ev.kind == hbd_pkg::EV_FLAG) ? count_q : 8'd0;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/hdlc_bit_deframer_fcs_check.sv -----
// HDLC receive deframer: one NRZI-decoded line bit per word on the input channel, one
// result word per input word on the output channel. Flags (0x7E) end a frame, stuffed
// zeros are dropped, bytes are assembled LSB first and reported with their frame index,
// and on a flag the frame length and the CRC-16/X-25 FCS verdict are reported. The block
// sustains one bit per clock unless the output stalls; an accepted input word is
// written into the queue, then its result word is taken into the back end's output
// register, which also absorbs the byte-wide CRC update. A two-word queue sits between
// the bit front end and the frame back end, so a stalled output lets two more words in
// before in_stall rises. min_frame_len (reset 17) is written through the cfg port, which
// is always ready; write it only while idle.
`timescale 1ns / 1ps
`default_nettype none
module hdlc_bit_deframer_fcs_check (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic       line_bit,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic            byte_valid,
	output logic [7:0]      data_byte,
	output logic [7:0]      byte_index,
	output logic            frame_end,
	output logic            frame_good,
	output logic [7:0]      frame_length
);

	hbd_pkg::ev_t  fe_ev;
	hbd_pkg::ev_t  be_ev;
	logic          q_push;
	logic          q_full;
	logic          q_pop;
	logic          q_empty;

	assign cfg_ready = 1'b1;

	hbd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.line_bit (line_bit),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_ev     (fe_ev)
	);

	hbd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_ev (fe_ev),
		.full    (q_full),
		.pop     (q_pop),
		.empty   (q_empty),
		.pop_ev  (be_ev)
	);

	hbd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_data     (cfg_data),
		.q_empty      (q_empty),
		.q_ev         (be_ev),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_end    (frame_end),
		.frame_good   (frame_good),
		.frame_length (frame_length)
	);

endmodule
`default_nettype wire

// ----- rtl/hbd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module hbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic       byte_valid,
	input wire logic [7:0] data_byte,
	input wire logic [7:0] byte_index,
	input wire logic       frame_end,
	input wire logic       frame_good,
	input wire logic [7:0] frame_length
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(data_byte) && $stable(byte_index)
			&& $stable(frame_end) && $stable(frame_length))
		else $error("output word changed while stalled");

	a_flag_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_end |-> !byte_valid && data_byte == 8'd0 && byte_index == 8'd0)
		else $error("flag word carries byte fields");

	a_byte_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !frame_end |-> !frame_good && frame_length == 8'd0)
		else $error("frame fields set without flag");

	a_good_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_good |-> frame_length >= 8'd2)
		else $error("good frame shorter than FCS");

	a_idle_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> data_byte == 8'd0 && byte_index == 8'd0)
		else $error("byte fields set without byte");

endmodule

bind hdlc_bit_deframer_fcs_check hbd_checker u_hbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.byte_valid   (byte_valid),
	.data_byte    (data_byte),
	.byte_index   (byte_index),
	.frame_end    (frame_end),
	.frame_good   (frame_good),
	.frame_length (frame_length)
);
`default_nettype wire

// ----- tb/sv/hdlc_bit_deframer_fcs_check_tb.sv -----
`timescale 1ns / 1ps
module hdlc_bit_deframer_fcs_check_tb;

	localparam int CYCLE_LIMIT  = 600000;
	localparam int RANDOM_BITS  = 400;
	localparam int DRAIN_CYCLES = 6;

	typedef enum int {FCS_GOOD, FCS_BAD, FCS_NONE} fcs_mode_t;

	typedef struct packed {
		logic       byte_valid;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		logic       frame_end;
		logic       frame_good;
		logic [7:0] frame_length;
	} deframe_result_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_valid = 1'b0;
	logic [7:0] cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       line_bit  = 1'b0;
	logic       out_stall = 1'b0;
	logic       cfg_ready;
	logic       in_stall;
	logic       out_valid;
	logic       byte_valid;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic       frame_end;
	logic       frame_good;
	logic [7:0] frame_length;

	hdlc_bit_deframer_fcs_check dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.line_bit     (line_bit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.byte_valid   (byte_valid),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_end    (frame_end),
		.frame_good   (frame_good),
		.frame_length (frame_length)
	);

	always #5 clk = ~clk;

	// deframer shadow state
	logic [7:0]  min_len;
	logic [7:0]  shadow_raw;
	logic [2:0]  shadow_ones;
	logic [7:0]  shadow_asm;
	int          shadow_nbits;
	int          shadow_count;
	logic [15:0] shadow_crc;
	logic [7:0]  shadow_held [2];

	deframe_result_t result_q [$];

	int   errors      = 0;
	int   cycle_count = 0;
	int   sent_bits   = 0;
	int   stall_pct   = 25;
	int   gap_max     = 4;
	int   burst_left  = 0;
	logic hold_off    = 1'b0;

	function automatic logic [15:0] x25_crc_step(input logic [15:0] crc, input logic [7:0] val);
		logic [15:0] c;
		logic fb;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ val[i];
			c = c >> 1;
			if (fb)
				c = c ^ hbd_pkg::CRC_POLY;
		end
		return c;
	endfunction

	task automatic clear_frame_state();
		shadow_raw     = '0;
		shadow_ones    = '0;
		shadow_asm     = '0;
		shadow_nbits   = 0;
		shadow_count   = 0;
		shadow_crc     = hbd_pkg::CRC_INIT;
		shadow_held[0] = '0;
		shadow_held[1] = '0;
	endtask

	task automatic predict_line_bit(input logic lb);
		deframe_result_t e;
		logic take;
		e = '0;
		take = 1'b0;
		shadow_raw = {shadow_raw[6:0], lb};
		if (shadow_raw == hbd_pkg::FLAG_PATTERN) begin
			e.frame_end = 1'b1;
			e.frame_length = shadow_count[7:0];
			// FCS needs two held bytes regardless of the length register
			if (shadow_count >= int'(min_len) && shadow_count >= 2)
				e.frame_good = ((shadow_crc ^ 16'hFFFF) == {shadow_held[1], shadow_held[0]});
			clear_frame_state();
		end else begin
			if (!lb) begin
				if (shadow_ones < hbd_pkg::STUFF_RUN)
					take = 1'b1;
				shadow_ones = '0;
			end else begin
				take = 1'b1;
				if (shadow_ones < hbd_pkg::ONES_SAT)
					shadow_ones = shadow_ones + 3'd1;
			end
			if (take) begin
				shadow_asm = {lb, shadow_asm[7:1]};
				shadow_nbits++;
			end
			if (shadow_nbits == 8) begin
				// overflow restarts the frame at index 0
				if (shadow_count >= int'(hbd_pkg::MAX_FRAME_BYTES)) begin
					shadow_count = 0;
					shadow_crc = hbd_pkg::CRC_INIT;
				end
				if (shadow_count >= 2)
					shadow_crc = x25_crc_step(shadow_crc, shadow_held[0]);
				shadow_held[0] = shadow_held[1];
				shadow_held[1] = shadow_asm;
				e.byte_valid = 1'b1;
				e.data_byte = shadow_asm;
				e.byte_index = shadow_count[7:0];
				shadow_count++;
				shadow_nbits = 0;
			end
		end
		result_q.push_back(e);
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d, want %0d", $time, what, got, want);
		errors++;
	endtask

	// sender: bursts with random gaps in between
	task automatic send_bit(input logic lb);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		line_bit <= lb;
		do @(posedge clk); while (in_stall);
		predict_line_bit(lb);
		sent_bits++;
	endtask

	task automatic send_flag();
		for (int i = 7; i >= 0; i--)
			send_bit(hbd_pkg::FLAG_PATTERN[i]);
	endtask

	task automatic send_frame(input int n_payload, input fcs_mode_t fcs_mode, input int cut_bits,
			input logic open_flag);
		logic [7:0]  body [$];
		logic        stream [$];
		logic [15:0] crc;
		int          ones;
		int          pos;
		int          cut;
		for (int i = 0; i < n_payload; i++)
			body.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom_range(0, 255)));
		if (fcs_mode != FCS_NONE) begin
			crc = hbd_pkg::CRC_INIT;
			foreach (body[i])
				crc = x25_crc_step(crc, body[i]);
			crc = ~crc;
			body.push_back(crc[7:0]);
			body.push_back(crc[15:8]);
			if (fcs_mode == FCS_BAD) begin
				pos = $urandom_range(0, body.size() - 1);
				body[pos] = body[pos] ^ (8'h01 << $urandom_range(0, 7));
			end
		end
		ones = 0;
		foreach (body[i]) begin
			for (int k = 0; k < 8; k++) begin
				stream.push_back(body[i][k]);
				ones = body[i][k] ? ones + 1 : 0;
				if (ones == int'(hbd_pkg::STUFF_RUN)) begin
					stream.push_back(1'b0);
					ones = 0;
				end
			end
		end
		cut = cut_bits;
		while (cut > 0 && stream.size() > 0) begin
			void'(stream.pop_back());
			cut--;
		end
		if (open_flag)
			send_flag();
		foreach (stream[i])
			send_bit(stream[i]);
		send_flag();
	endtask

	task automatic send_noise(input int n);
		repeat ($urandom_range(0, 14))
			send_bit(1'b1);
		repeat (n)
			send_bit(1'($urandom_range(0, 1)));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_min_len(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		min_len = v;
	endtask

	task automatic hold_receiver(input int n);
		hold_off <= 1'b1;
		repeat (n) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	task automatic test_bare_flag();
		send_flag();
		send_flag();
	endtask

	task automatic test_reset_min_len();
		send_frame(15, FCS_GOOD, 0, 1'b0);
		send_frame(14, FCS_GOOD, 0, 1'b0);
		wait_drained();
	endtask

	task automatic test_short_frames();
		write_min_len(8'd0);
		send_frame(1, FCS_NONE, 0, 1'b0);
		send_frame(0, FCS_GOOD, 0, 1'b0);
		wait_drained();
		write_min_len(8'd1);
		send_frame(1, FCS_NONE, 0, 1'b0);
		send_frame(0, FCS_GOOD, 0, 1'b0);
		wait_drained();
		write_min_len(8'd3);
		send_frame(1, FCS_GOOD, 0, 1'b0);
		send_frame(0, FCS_GOOD, 0, 1'b0);
		send_frame(1, FCS_BAD, 0, 1'b0);
		wait_drained();
	endtask

	task automatic test_ones_run();
		// long run saturates the ones counter, then a lone stuffed zero
		send_bit(1'b0);
		repeat (14) send_bit(1'b1);
		send_bit(1'b0);
		repeat (5) send_bit(1'b1);
		send_bit(1'b0);
		send_frame(4, FCS_GOOD, 3, 1'b1);
		wait_drained();
	endtask

	task automatic test_receiver_hold();
		stall_pct <= 20;
		gap_max = 0;
		fork
			hold_receiver(400);
			send_frame(10, FCS_GOOD, 0, 1'b1);
		join
		wait_drained();
	endtask

	task automatic test_longest_frame();
		// 256 bytes: the last FCS byte overflows and restarts the frame
		stall_pct <= 10;
		gap_max = 2;
		send_frame(254, FCS_GOOD, 0, 1'b0);
		wait_drained();
	endtask

	task automatic test_random_traffic();
		int start;
		int pick;
		start = sent_bits;
		while (sent_bits - start < RANDOM_BITS) begin
			if (sent_bits == start || $urandom_range(0, 7) == 0) begin
				wait_drained();
				case ($urandom_range(0, 5))
					0: write_min_len(8'd0);
					1: write_min_len(8'd3);
					2: write_min_len(8'd255);
					default: write_min_len(8'($urandom_range(1, 24)));
				endcase
				case ($urandom_range(0, 4))
					0, 1: stall_pct <= 0;
					2: stall_pct <= 15;
					3: stall_pct <= 50;
					default: stall_pct <= 85;
				endcase
				case ($urandom_range(0, 2))
					0: gap_max = 0;
					1: gap_max = 2;
					default: gap_max = 12;
				endcase
			end
			pick = $urandom_range(0, 19);
			if (pick < 13)
				send_frame($urandom_range(0, 20), FCS_GOOD, 0, 1'($urandom_range(0, 1)));
			else if (pick < 15)
				send_frame($urandom_range(0, 20), FCS_BAD, 0, 1'b1);
			else if (pick < 17)
				send_frame($urandom_range(0, 12), FCS_GOOD, $urandom_range(1, 12), 1'b1);
			else if (pick < 18)
				send_frame($urandom_range(0, 6), FCS_NONE, 0, 1'b1);
			else
				send_noise($urandom_range(4, 40));
		end
	endtask

	// receiver stall and result word check
	always @(posedge clk) begin
		deframe_result_t want;
		out_stall <= hold_off || ($urandom_range(0, 99) < stall_pct);
		if (arst_n && out_valid && !out_stall) begin
			if (result_q.size() == 0) begin
				report_mismatch("word with nothing pending", 0, 0);
			end else begin
				want = result_q.pop_front();
				if (byte_valid !== want.byte_valid)
					report_mismatch("byte_valid", byte_valid, want.byte_valid);
				if (data_byte !== want.data_byte)
					report_mismatch("data_byte", data_byte, want.data_byte);
				if (byte_index !== want.byte_index)
					report_mismatch("byte_index", byte_index, want.byte_index);
				if (frame_end !== want.frame_end)
					report_mismatch("frame_end", frame_end, want.frame_end);
				if (frame_good !== want.frame_good)
					report_mismatch("frame_good", frame_good, want.frame_good);
				if (frame_length !== want.frame_length)
					report_mismatch("frame_length", frame_length, want.frame_length);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("hdlc_bit_deframer_fcs_check verification failed");
			$finish;
		end
	end

	initial begin
		min_len = hbd_pkg::MIN_LEN_RESET;
		clear_frame_state();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_bare_flag();
		test_reset_min_len();
		test_short_frames();
		test_ones_run();
		test_receiver_hold();
		test_longest_frame();
		test_random_traffic();
		wait_drained();
		if (errors == 0)
			$display("hdlc_bit_deframer_fcs_check verification clean");
		else
			$display("hdlc_bit_deframer_fcs_check verification failed");
		$finish;
	end

endmodule
